// ===== hdl/vspd_pkg.sv =====
package vspd_pkg;

	localparam int unsigned RawW   = 12;
	localparam int unsigned LevelW = 10;
	localparam int unsigned TimeW  = 32;
	localparam int unsigned LoadW  = 8;
	localparam int unsigned SpanW  = 16;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [RawW-1:0] RawMax = RawW'(1023);

	localparam logic [CfgIdxW-1:0] REG_RISE_THRESHOLD   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_FALL_THRESHOLD   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_NOISE_MARGIN     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_FRESH_GAP        = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_STARTUP_HOLD     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_CONFIRM_TIME     = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_RECONNECT_WINDOW = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_RISE_WINDOW      = 3'd7;

	localparam logic [LevelW-1:0] RiseDefault      = 10'd32;
	localparam logic [LevelW-1:0] FallDefault      = 10'd16;
	localparam logic [LevelW-1:0] NoiseDefault     = 10'd4;
	localparam logic [SpanW-1:0]  FreshDefault     = 16'd2000;
	localparam logic [SpanW-1:0]  StartupDefault   = 16'd3000;
	localparam logic [SpanW-1:0]  ConfirmDefault   = 16'd400;
	localparam logic [SpanW-1:0]  ReconnectDefault = 16'd10000;
	localparam logic [SpanW-1:0]  RiseWinDefault   = 16'd3000;

	typedef enum logic [1:0] {
		PH_BASELINE = 2'd0,
		PH_RISE     = 2'd1,
		PH_CONFIRM  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [LevelW-1:0] rise_threshold;
		logic [LevelW-1:0] fall_threshold;
		logic [LevelW-1:0] noise_margin;
		logic [SpanW-1:0]  fresh_gap;
		logic [SpanW-1:0]  startup_hold;
		logic [SpanW-1:0]  confirm_time;
		logic [SpanW-1:0]  reconnect_window;
		logic [SpanW-1:0]  rise_window;
	} cfg_t;

	typedef struct packed {
		logic [RawW-1:0]  raw_level;
		logic [TimeW-1:0] time_ms;
		logic             sample_valid;
		logic [LoadW-1:0] load_state;
	} sample_t;

	typedef struct packed {
		logic              tracking;
		logic [TimeW-1:0]  init_time;
		logic [TimeW-1:0]  last_sample_time;
		logic [LevelW-1:0] baseline;
		logic [TimeW-1:0]  threshold_since;
		phase_t            pending_phase;
		logic [TimeW-1:0]  pending_since;
		logic [LevelW-1:0] peak_level;
		logic              active_flag;
		logic [LoadW-1:0]  last_load;
		logic              rearm_flag;
		logic [TimeW-1:0]  release_time;
	} state_t;

endpackage

// ===== hdl/vspd_if.sv =====
interface vspd_sample_if;
	logic                        valid;
	logic                        ready;
	logic [vspd_pkg::RawW-1:0]   raw_level;
	logic [vspd_pkg::TimeW-1:0]  time_ms;
	logic                        sample_valid;
	logic [vspd_pkg::LoadW-1:0]  load_state;

	modport source (output valid, raw_level, time_ms, sample_valid, load_state, input ready);
	modport sink (input valid, raw_level, time_ms, sample_valid, load_state, output ready);
endinterface

interface vspd_result_if;
	logic valid;
	logic ready;
	logic charging_active;

	modport source (output valid, charging_active, input ready);
	modport sink (input valid, charging_active, output ready);
endinterface

// ===== hdl/voltage_step_presence_detector_unit.sv =====
// Voltage step presence detector.
// Channels: "sample" takes one word per sample (raw_level, time_ms,
// sample_valid, load_state); "result" gives one word per sample carrying
// charging_active. Both use valid/ready; a word moves when both are high.
// Configuration: cfg_we with cfg_index 0..7 writes cfg_data into the
// matching register; write only while no sample is in flight.
// Path: a sample goes through the input register, then the tracker update
// into the result register; a stalled result can hold it in between.
// Throughput: one sample per cycle while results are taken; the tracker
// update between input and result register is combinational.
// Reset: all tracker state and both stage valids clear; registers return
// to their defaults. Nothing is emitted until a sample is accepted.
// Stall: a held result keeps its value; the input register still fills,
// and sample.ready drops only while both stages are full and the result
// is not taken.
module voltage_step_presence_detector_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	vspd_sample_if.sink                   sample,
	vspd_result_if.source                 result,
	input  logic                          cfg_we,
	input  logic [vspd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [vspd_pkg::CfgDataW-1:0] cfg_data
);

	vspd_pkg::cfg_t    cfg;
	vspd_pkg::sample_t item_s1;
	logic              valid_s1;
	logic              valid_s2;
	logic              active_s2;
	logic              active_d;
	logic              advance;

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;

	vspd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	vspd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.cfg      (cfg),
		.active_d (active_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample.ready)
				valid_s1 <= sample.valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (result.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			item_s1.raw_level    <= sample.raw_level;
			item_s1.time_ms      <= sample.time_ms;
			item_s1.sample_valid <= sample.sample_valid;
			item_s1.load_state   <= sample.load_state;
		end
		if (advance)
			active_s2 <= active_d;
	end

	assign result.valid           = valid_s2;
	assign result.charging_active = active_s2;

endmodule

// ===== hdl/vspd_cfg.sv =====
module vspd_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [vspd_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [vspd_pkg::CfgDataW-1:0]    cfg_data,
	output vspd_pkg::cfg_t                   cfg
);

	vspd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_threshold   <= vspd_pkg::RiseDefault;
			cfg_q.fall_threshold   <= vspd_pkg::FallDefault;
			cfg_q.noise_margin     <= vspd_pkg::NoiseDefault;
			cfg_q.fresh_gap        <= vspd_pkg::FreshDefault;
			cfg_q.startup_hold     <= vspd_pkg::StartupDefault;
			cfg_q.confirm_time     <= vspd_pkg::ConfirmDefault;
			cfg_q.reconnect_window <= vspd_pkg::ReconnectDefault;
			cfg_q.rise_window      <= vspd_pkg::RiseWinDefault;
		end else if (cfg_we) begin
			case (cfg_index)
				vspd_pkg::REG_RISE_THRESHOLD:   cfg_q.rise_threshold   <= cfg_data[9:0];
				vspd_pkg::REG_FALL_THRESHOLD:   cfg_q.fall_threshold   <= cfg_data[9:0];
				vspd_pkg::REG_NOISE_MARGIN:     cfg_q.noise_margin     <= cfg_data[9:0];
				vspd_pkg::REG_FRESH_GAP:        cfg_q.fresh_gap        <= cfg_data;
				vspd_pkg::REG_STARTUP_HOLD:     cfg_q.startup_hold     <= cfg_data;
				vspd_pkg::REG_CONFIRM_TIME:     cfg_q.confirm_time     <= cfg_data;
				vspd_pkg::REG_RECONNECT_WINDOW: cfg_q.reconnect_window <= cfg_data;
				vspd_pkg::REG_RISE_WINDOW:      cfg_q.rise_window      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/vspd_core.sv =====
module vspd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  vspd_pkg::sample_t item,
	input  vspd_pkg::cfg_t    cfg,
	output logic              active_d
);

	vspd_pkg::state_t st_q;
	vspd_pkg::state_t st_d;

	logic [vspd_pkg::LevelW-1:0] raw;
	logic [vspd_pkg::TimeW-1:0]  t;
	logic [vspd_pkg::TimeW-1:0]  gap_dt;
	logic [vspd_pkg::TimeW-1:0]  init_dt;
	logic [vspd_pkg::TimeW-1:0]  rel_dt;
	logic [vspd_pkg::LevelW:0]   raw_fall;
	logic [vspd_pkg::LevelW:0]   raw_noise;
	logic [vspd_pkg::LevelW:0]   base_fall;
	logic [vspd_pkg::LevelW:0]   base_noise;
	logic [vspd_pkg::LevelW:0]   base_rise;
	logic                        changed;
	logic                        paired;

	assign raw     = item.raw_level[vspd_pkg::LevelW-1:0];
	assign t       = item.time_ms;
	assign gap_dt  = t - st_q.last_sample_time;
	assign init_dt = t - st_q.init_time;
	assign rel_dt  = t - st_q.release_time;
	assign raw_fall   = {1'b0, raw} + {1'b0, cfg.fall_threshold};
	assign raw_noise  = {1'b0, raw} + {1'b0, cfg.noise_margin};
	assign base_fall  = {1'b0, st_q.baseline} + {1'b0, cfg.fall_threshold};
	assign base_noise = {1'b0, st_q.baseline} + {1'b0, cfg.noise_margin};
	assign base_rise  = {1'b0, st_q.baseline} + {1'b0, cfg.rise_threshold};

	always_comb begin
		st_d    = st_q;
		changed = (item.load_state != st_q.last_load);
		paired  = 1'b0;
		if (!item.sample_valid || item.raw_level > vspd_pkg::RawMax) begin
			st_d.tracking    = 1'b0;
			st_d.active_flag = 1'b0;
			st_d.rearm_flag  = 1'b0;
		end else if (!st_q.tracking || gap_dt > {16'd0, cfg.fresh_gap}) begin
			st_d.tracking         = 1'b1;
			st_d.init_time        = t;
			st_d.last_sample_time = t;
			st_d.baseline         = raw;
			st_d.active_flag      = 1'b0;
			st_d.pending_phase    = vspd_pkg::PH_BASELINE;
			st_d.rearm_flag       = 1'b0;
			st_d.last_load        = item.load_state;
		end else begin
			st_d.last_sample_time = t;
			st_d.last_load        = item.load_state;
			if (changed)
				st_d.rearm_flag = 1'b0;
			if (init_dt < {16'd0, cfg.startup_hold}) begin
				st_d.baseline      = raw;
				st_d.pending_phase = vspd_pkg::PH_BASELINE;
				st_d.active_flag   = 1'b0;
				st_d.rearm_flag    = 1'b0;
			end else if (st_q.active_flag) begin
				if (changed && raw_fall > {1'b0, st_q.peak_level}) begin
					st_d.peak_level    = raw;
					st_d.pending_phase = vspd_pkg::PH_BASELINE;
				end
				if (raw_fall <= {1'b0, st_d.peak_level}) begin
					if (st_d.pending_phase == vspd_pkg::PH_BASELINE) begin
						st_d.pending_phase = vspd_pkg::PH_RISE;
						st_d.pending_since = t;
					end
					if ((t - st_d.pending_since) >= {16'd0, cfg.confirm_time}) begin
						st_d.active_flag   = 1'b0;
						st_d.pending_phase = vspd_pkg::PH_BASELINE;
						st_d.baseline      = raw;
						st_d.release_time  = t;
					end
				end else begin
					st_d.pending_phase = vspd_pkg::PH_BASELINE;
					if (raw > st_d.peak_level)
						st_d.peak_level = raw;
				end
			end else begin
				if (rel_dt > {16'd0, cfg.reconnect_window})
					st_d.rearm_flag = 1'b0;
				if (changed) begin
					st_d.baseline      = raw;
					st_d.pending_phase = vspd_pkg::PH_BASELINE;
				end else if (raw <= st_q.baseline ||
						(st_q.pending_phase != vspd_pkg::PH_BASELINE &&
						(t - st_q.pending_since) > {16'd0, cfg.rise_window})) begin
					st_d.baseline      = raw;
					st_d.pending_phase = vspd_pkg::PH_BASELINE;
				end else if ({1'b0, raw} > base_noise ||
						st_q.pending_phase != vspd_pkg::PH_BASELINE) begin
					if (st_d.pending_phase == vspd_pkg::PH_BASELINE) begin
						st_d.pending_phase = vspd_pkg::PH_RISE;
						st_d.pending_since = t;
					end
					paired = st_d.rearm_flag && raw_noise >= base_fall &&
						raw_noise >= {1'b0, st_q.peak_level};
					if ({1'b0, raw} >= base_rise || paired) begin
						if (st_d.pending_phase != vspd_pkg::PH_CONFIRM) begin
							st_d.pending_phase   = vspd_pkg::PH_CONFIRM;
							st_d.threshold_since = t;
						end
						if ((t - st_d.threshold_since) >= {16'd0, cfg.confirm_time}) begin
							st_d.active_flag   = 1'b1;
							st_d.rearm_flag    = 1'b1;
							st_d.pending_phase = vspd_pkg::PH_BASELINE;
							if (!paired || raw > st_q.peak_level)
								st_d.peak_level = raw;
						end
					end else begin
						st_d.pending_phase = vspd_pkg::PH_RISE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{default: '0, pending_phase: vspd_pkg::PH_BASELINE};
		end else if (advance) begin
			st_q <= st_d;
		end
	end

	assign active_d = st_d.active_flag;

endmodule
